// ===== rtl/fmp_pkg.sv =====
// Shared types and defaults for the Fibonacci matrix-power core.
// No dependencies; used by fmp_mac and fibonacci_matrix_power_core.
package fmp_pkg;

  // Default widths of the result value and of the index
  localparam int VALUE_BITS_DEF = 64;
  localparam int INDEX_BITS_DEF = 31;

  // Which partial product of a split multiply is being formed
  typedef enum logic [1:0] {
    PART_LL,   // low x low, no shift
    PART_LH,   // low of x times high of y, shifted up by the low half width
    PART_HL    // high of x times low of y, shifted up by the low half width
  } part_t;

  // Control from the sequencer to the shared multiply-accumulate unit
  typedef struct packed {
    logic  en;     // issue one partial product this cycle
    logic  clr;    // this partial product starts a new sum
    part_t part;
  } mac_ctrl_t;

endpackage

// ===== rtl/fmp_mac.sv =====
// Shared multiply-accumulate unit: one half-width multiplier, registered,
// followed by a wrapping accumulator. Depends on fmp_pkg.
module fmp_mac #(
  parameter int VALUE_BITS = fmp_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fmp_pkg::mac_ctrl_t     ctrl,
  input  logic [VALUE_BITS-1:0]  x,
  input  logic [VALUE_BITS-1:0]  y,
  output logic [VALUE_BITS-1:0]  acc
);
  import fmp_pkg::*;

  localparam int LO_BITS = (VALUE_BITS + 1) / 2;
  localparam int PROD_BITS = 2 * LO_BITS;

  logic [LO_BITS-1:0]    x_op;
  logic [LO_BITS-1:0]    y_op;
  logic [PROD_BITS-1:0]  x_ext;
  logic [PROD_BITS-1:0]  y_ext;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  prod_sh;
  logic [VALUE_BITS-1:0] addend;
  logic                  en_d;
  logic                  clr_d;
  logic                  cross_d;

  // Operand halves for the requested partial product
  always_comb begin
    x_op = x[LO_BITS-1:0];
    y_op = y[LO_BITS-1:0];
    case (ctrl.part)
      PART_LL: begin
        x_op = x[LO_BITS-1:0];
        y_op = y[LO_BITS-1:0];
      end
      PART_LH: begin
        x_op = x[LO_BITS-1:0];
        y_op = LO_BITS'(y[VALUE_BITS-1:LO_BITS]);
      end
      PART_HL: begin
        x_op = LO_BITS'(x[VALUE_BITS-1:LO_BITS]);
        y_op = y[LO_BITS-1:0];
      end
      default: begin
        x_op = x[LO_BITS-1:0];
        y_op = y[LO_BITS-1:0];
      end
    endcase
  end

  assign x_ext = {{(PROD_BITS - LO_BITS){1'b0}}, x_op};
  assign y_ext = {{(PROD_BITS - LO_BITS){1'b0}}, y_op};

  // Cross terms only contribute their low bits, moved up by LO_BITS
  assign prod_sh = prod << LO_BITS;
  assign addend  = cross_d ? prod_sh[VALUE_BITS-1:0] : prod[VALUE_BITS-1:0];

  // Multiplier stage
  always_ff @(posedge clk) begin
    prod    <= x_ext * y_ext;
    cross_d <= (ctrl.part != PART_LL);
    if (rst) begin
      en_d  <= 1'b0;
      clr_d <= 1'b0;
    end else begin
      en_d  <= ctrl.en;
      clr_d <= ctrl.clr;
    end
  end

  // Accumulator stage, wraps modulo 2^VALUE_BITS
  always_ff @(posedge clk) begin
    if (en_d) begin
      acc <= (clr_d ? '0 : acc) + addend;
    end
  end

endmodule

// ===== rtl/fibonacci_matrix_power_core.sv =====
// Fibonacci core: raises [[1,1],[1,0]] to the index by square-and-multiply
// and returns Fibonacci(index+1). Depends on fmp_pkg and fmp_mac.
//
// One request at a time: index_stall is high from the cycle after a request
// is taken until its result is loaded into the output register, which then
// waits for the consumer while the next request may already be accepted.
// All work runs through a single half-width multiplier: a matrix product
// forms only the top-left and top-right entries, each a sum of two products
// split into three partial products apiece, and takes the bottom-right entry
// as their difference. Each index bit up to the highest set bit multiplies
// into the result when the bit is set, then squares unless it is the last
// bit. The result wraps modulo 2^VALUE_BITS. No state carries over between
// requests.
module fibonacci_matrix_power_core #(
  parameter int VALUE_BITS = fmp_pkg::VALUE_BITS_DEF,
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  index_valid,
  output logic                  index_stall,
  input  logic [INDEX_BITS-1:0] index,
  output logic                  value_valid,
  input  logic                  value_stall,
  output logic [VALUE_BITS-1:0] value
);
  import fmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                state;
  logic [INDEX_BITS-1:0] e;
  logic [INDEX_BITS-1:0] e_shr;
  // Powers of the Fibonacci matrix are symmetric: keep a, b (= c) and d
  logic [VALUE_BITS-1:0] acc_a, acc_b, acc_d;
  logic [VALUE_BITS-1:0] sq_a, sq_b, sq_d;
  logic [VALUE_BITS-1:0] tmp_a;
  logic                  tgt_sq;   // product goes to sq (squaring) else acc
  logic                  half;     // 0: top-left entry, 1: top-right entry
  logic                  term;     // which of the two products in the sum
  part_t                 part;
  mac_ctrl_t             mac_ctrl;
  logic [VALUE_BITS-1:0] x_a, x_b;
  logic [VALUE_BITS-1:0] mac_x, mac_y;
  logic [VALUE_BITS-1:0] mac_acc;

  assign index_stall = (state != S_IDLE);
  assign e_shr       = e >> 1;

  // Operand selection: r.a = x.a*y.a + x.b*y.b, r.b = x.a*y.b + x.b*y.d
  always_comb begin
    x_a   = tgt_sq ? sq_a : acc_a;
    x_b   = tgt_sq ? sq_b : acc_b;
    mac_x = term ? x_b : x_a;
    case ({half, term})
      2'b00:   mac_y = sq_a;
      2'b01:   mac_y = sq_b;
      2'b10:   mac_y = sq_b;
      2'b11:   mac_y = sq_d;
      default: mac_y = sq_a;
    endcase
  end

  assign mac_ctrl.en   = (state == S_ISSUE);
  assign mac_ctrl.clr  = !term && (part == PART_LL);
  assign mac_ctrl.part = part;

  fmp_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .x    (mac_x),
    .y    (mac_y),
    .acc  (mac_acc)
  );

  // Sequencer, matrix registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      value_valid <= 1'b0;
      tgt_sq      <= 1'b0;
      half        <= 1'b0;
      term        <= 1'b0;
      part        <= PART_LL;
    end else begin
      // Output register empties when taken, unless a new result loads now
      if (value_valid && !value_stall && state != S_DONE) begin
        value_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (index_valid) begin
            e     <= index;
            acc_a <= VALUE_BITS'(1);
            acc_b <= '0;
            acc_d <= VALUE_BITS'(1);
            sq_a  <= VALUE_BITS'(1);
            sq_b  <= VALUE_BITS'(1);
            sq_d  <= '0;
            state <= S_BIT;
          end
        end
        // Finish when no bits remain; multiply into acc when the current bit is set, else go to the next bit
        S_BIT: begin
          if (e == '0) begin
            state <= S_DONE;
          end else if (e[0]) begin
            tgt_sq <= 1'b0;
            half   <= 1'b0;
            term   <= 1'b0;
            part   <= PART_LL;
            state  <= S_ISSUE;
          end else begin
            state <= S_SHIFT;
          end
        end
        // Three partial products per term, two terms per entry
        S_ISSUE: begin
          case (part)
            PART_LL: part <= PART_LH;
            PART_LH: part <= PART_HL;
            PART_HL: begin
              part <= PART_LL;
              if (term) begin
                term  <= 1'b0;
                state <= S_DRAIN1;
              end else begin
                term <= 1'b1;
              end
            end
            default: part <= PART_LL;
          endcase
        end
        S_DRAIN1: begin
          state <= S_DRAIN2;
        end
        S_DRAIN2: begin
          if (!half) begin
            tmp_a <= mac_acc;
            half  <= 1'b1;
            state <= S_ISSUE;
          end else begin
            half <= 1'b0;
            if (tgt_sq) begin
              sq_a  <= tmp_a;
              sq_b  <= mac_acc;
              sq_d  <= tmp_a - mac_acc;
              state <= S_BIT;
            end else begin
              acc_a <= tmp_a;
              acc_b <= mac_acc;
              acc_d <= tmp_a - mac_acc;
              state <= S_SHIFT;
            end
          end
        end
        // Next bit; square only while higher bits remain
        S_SHIFT: begin
          e <= e_shr;
          if (e_shr != '0) begin
            tgt_sq <= 1'b1;
            half   <= 1'b0;
            term   <= 1'b0;
            part   <= PART_LL;
            state  <= S_ISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!value_valid || !value_stall) begin
            value       <= acc_a;
            value_valid <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only appears out of the finishing state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(value_valid) |-> ($past(state) == S_DONE))
    else $error("result presented outside finishing state");

  // Products into acc happen only for set index bits
  a_mul_on_set_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && !tgt_sq) |-> e[0])
    else $error("acc product issued for a clear index bit");

  // A taken request starts bit processing next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (index_valid && !index_stall) |=> (state == S_BIT))
    else $error("accepted request did not start");

  // Matrix powers keep a == b + d
  a_fib_form: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIT) |-> (acc_a == acc_b + acc_d && sq_a == sq_b + sq_d))
    else $error("matrix register lost Fibonacci form");

endmodule
